### hdl/calendar_clock_counter_top_macros.svh
// Assertion macros for the calendar clock counter.
// Used by calendar_clock_counter_top; expects clk and rst_n in scope.
`ifndef CALENDAR_CLOCK_COUNTER_TOP_MACROS_SVH
`define CALENDAR_CLOCK_COUNTER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define CCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calendar_clock_counter: assertion failed");

// Next-cycle implication.
`define CCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar_clock_counter: assertion failed");

`else

`define CCC_ASSERT_NOW(label, ante, cons)
`define CCC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### hdl/ccc_pkg.sv
// Shared types, constants and the month length table for the calendar counter.
// No dependencies.
package ccc_pkg;

    // Request kinds (req_type field)
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    localparam logic [5:0]  SEC_LAST     = 6'd59;
    localparam logic [5:0]  MIN_LAST     = 6'd59;
    localparam logic [4:0]  HOUR_LAST    = 5'd23;
    localparam logic [5:0]  SEC_LIMIT    = 6'd60;
    localparam logic [5:0]  MIN_LIMIT    = 6'd60;
    localparam logic [4:0]  HOUR_LIMIT   = 5'd24;
    localparam logic [3:0]  MONTH_LAST   = 4'd12;
    localparam logic [3:0]  MONTH_LIMIT  = 4'd13;
    localparam logic [3:0]  MONTH_FEB    = 4'd2;
    localparam logic [5:0]  DAY_LEAP     = 6'd29;
    localparam logic [13:0] YEAR_LAST    = 14'd9999;
    localparam logic [11:0] YEAR_LOAD_LO = 12'd1920;
    localparam logic [11:0] YEAR_LOAD_HI = 12'd2020;
    localparam logic [13:0] YEAR_DEFAULT = 14'd2011;
    localparam logic [11:0] YEAR_2000    = 12'd2000;
    localparam logic [11:0] YEAR_1900    = 12'd1900;
    localparam logic [11:0] YEAR_1600    = 12'd1600;
    localparam logic [6:0]  MOD100_LAST  = 7'd99;
    localparam logic [8:0]  MOD400_LAST  = 9'd399;
    localparam logic [6:0]  DEFAULT_MOD100 = 7'd11;   // 2011 % 100
    localparam logic [8:0]  DEFAULT_MOD400 = 9'd11;   // 2011 % 400

    typedef struct packed {
        logic        req_type;
        logic [11:0] set_year;
        logic [3:0]  set_month;
        logic [4:0]  set_day;
        logic [4:0]  set_hour;
        logic [5:0]  set_minute;
        logic [5:0]  set_second;
    } req_t;

    typedef struct packed {
        logic [13:0] cur_year;
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic [4:0]  cur_hour;
        logic [5:0]  cur_minute;
        logic [5:0]  cur_second;
    } rsp_t;

    // Calendar state; year % 100 and year % 400 are tracked alongside the year
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [6:0]  yr_mod100;
        logic [8:0]  yr_mod400;
    } cal_state_t;

    localparam cal_state_t STATE_RESET = '{
        year:      YEAR_DEFAULT,
        month:     4'd1,
        day:       5'd1,
        hour:      5'd0,
        minute:    6'd0,
        second:    6'd0,
        yr_mod100: DEFAULT_MOD100,
        yr_mod400: DEFAULT_MOD400
    };

    // Days per month; month 0 and codes above 12 have no valid days
    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] days;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   days = 5'd30;
            4'd2:                                      days = 5'd28;
            default:                                   days = 5'd0;
        endcase
        return days;
    endfunction

    // Day d valid for month m, with Feb 29 allowed in leap years
    function automatic logic day_valid(input logic [5:0] d, input logic [3:0] m,
                                       input logic leap);
        logic in_table;
        in_table = (d != 6'd0) && (d <= {1'b0, month_days(m)});
        return in_table || ((m == MONTH_FEB) && (d == DAY_LEAP) && leap);
    endfunction

endpackage

### hdl/ccc_in_stage.sv
// Input register stage of the calendar counter.
// Depends on ccc_pkg (req_t).
module ccc_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ccc_pkg::req_t req_data,
    input  logic          take,
    output logic          fire,
    output ccc_pkg::req_t item
);

    logic          valid_reg;
    logic          valid_next;
    ccc_pkg::req_t data_reg;
    logic          accept;

    assign req_stall = valid_reg && !take;
    assign fire      = valid_reg && take;
    assign accept    = req_valid && !req_stall;
    assign item      = data_reg;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= req_data;
        end
    end

endmodule

### hdl/ccc_core.sv
// Calendar state registers and the tick / load update logic.
// Depends on ccc_pkg (req_t, cal_state_t, month_days, day_valid).
module ccc_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  ccc_pkg::req_t       item,
    output ccc_pkg::cal_state_t state,
    output ccc_pkg::cal_state_t state_upd
);

    ccc_pkg::cal_state_t state_reg;
    ccc_pkg::cal_state_t state_next;
    ccc_pkg::cal_state_t tick_st;
    ccc_pkg::cal_state_t load_st;

    logic [5:0] day_inc;
    logic       leap_cur;
    logic       sec_wrap;
    logic       min_wrap;
    logic       hour_wrap;
    logic       day_wrap;
    logic       month_wrap;

    logic       y_ok;
    logic       leap_load;
    logic [3:0] month_load;

    // ---- tick path: cascaded carries ----
    assign day_inc    = {1'b0, state_reg.day} + 6'd1;
    assign leap_cur   = (state_reg.yr_mod400 == 9'd0) ||
                        ((state_reg.year[1:0] == 2'd0) && (state_reg.yr_mod100 != 7'd0));
    assign sec_wrap   = (state_reg.second >= ccc_pkg::SEC_LAST);
    assign min_wrap   = (state_reg.minute >= ccc_pkg::MIN_LAST);
    assign hour_wrap  = (state_reg.hour >= ccc_pkg::HOUR_LAST);
    assign day_wrap   = !ccc_pkg::day_valid(day_inc, state_reg.month, leap_cur);
    assign month_wrap = (state_reg.month >= ccc_pkg::MONTH_LAST);

    always_comb
    begin
        tick_st = state_reg;
        if (!sec_wrap)
        begin
            tick_st.second = state_reg.second + 6'd1;
        end
        else
        begin
            tick_st.second = 6'd0;
            if (!min_wrap)
            begin
                tick_st.minute = state_reg.minute + 6'd1;
            end
            else
            begin
                tick_st.minute = 6'd0;
                if (!hour_wrap)
                begin
                    tick_st.hour = state_reg.hour + 5'd1;
                end
                else
                begin
                    tick_st.hour = 5'd0;
                    if (!day_wrap)
                    begin
                        tick_st.day = day_inc[4:0];
                    end
                    else
                    begin
                        tick_st.day = 5'd1;
                        if (!month_wrap)
                        begin
                            tick_st.month = state_reg.month + 4'd1;
                        end
                        else
                        begin
                            tick_st.month = 4'd1;
                            if (state_reg.year >= ccc_pkg::YEAR_LAST)
                            begin
                                tick_st.year = 14'd0;
                            end
                            else
                            begin
                                tick_st.year = state_reg.year + 14'd1;
                            end
                            // 9999 -> 0 keeps both residues consistent
                            tick_st.yr_mod100 = (state_reg.yr_mod100 >= ccc_pkg::MOD100_LAST)
                                                ? 7'd0 : state_reg.yr_mod100 + 7'd1;
                            tick_st.yr_mod400 = (state_reg.yr_mod400 >= ccc_pkg::MOD400_LAST)
                                                ? 9'd0 : state_reg.yr_mod400 + 9'd1;
                        end
                    end
                end
            end
        end
    end

    // ---- load path: validate each field ----
    // Within 1920..2020 every multiple of 4 is a leap year; 2011 is not.
    assign y_ok       = (item.set_year >= ccc_pkg::YEAR_LOAD_LO) &&
                        (item.set_year <= ccc_pkg::YEAR_LOAD_HI);
    assign leap_load  = y_ok && (item.set_year[1:0] == 2'd0);
    assign month_load = (item.set_month < ccc_pkg::MONTH_LIMIT) ? item.set_month : 4'd1;

    always_comb
    begin
        load_st = state_reg;
        if (y_ok)
        begin
            load_st.year = {2'b00, item.set_year};
            if (item.set_year >= ccc_pkg::YEAR_2000)
            begin
                load_st.yr_mod100 = 7'(item.set_year - ccc_pkg::YEAR_2000);
                load_st.yr_mod400 = 9'(item.set_year - ccc_pkg::YEAR_2000);
            end
            else
            begin
                load_st.yr_mod100 = 7'(item.set_year - ccc_pkg::YEAR_1900);
                load_st.yr_mod400 = 9'(item.set_year - ccc_pkg::YEAR_1600);
            end
        end
        else
        begin
            load_st.year      = ccc_pkg::YEAR_DEFAULT;
            load_st.yr_mod100 = ccc_pkg::DEFAULT_MOD100;
            load_st.yr_mod400 = ccc_pkg::DEFAULT_MOD400;
        end
        load_st.month  = month_load;
        load_st.day    = ccc_pkg::day_valid({1'b0, item.set_day}, month_load, leap_load)
                         ? item.set_day : 5'd1;
        load_st.hour   = (item.set_hour < ccc_pkg::HOUR_LIMIT) ? item.set_hour : 5'd0;
        load_st.minute = (item.set_minute < ccc_pkg::MIN_LIMIT) ? item.set_minute : 6'd0;
        load_st.second = (item.set_second < ccc_pkg::SEC_LIMIT) ? item.set_second : 6'd0;
    end

    assign state_upd  = (item.req_type == ccc_pkg::REQ_LOAD) ? load_st : tick_st;
    assign state_next = fire ? state_upd : state_reg;
    assign state      = state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ccc_pkg::STATE_RESET;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/ccc_out_stage.sv
// Result register stage of the calendar counter.
// Depends on ccc_pkg (cal_state_t, rsp_t).
module ccc_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  ccc_pkg::cal_state_t state_upd,
    output logic                take,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output ccc_pkg::rsp_t       rsp_data
);

    logic          valid_reg;
    logic          valid_next;
    ccc_pkg::rsp_t data_reg;
    ccc_pkg::rsp_t data_next;

    assign take       = !valid_reg || !rsp_stall;
    assign valid_next = take ? fire : valid_reg;

    assign data_next = '{
        cur_year:   state_upd.year,
        cur_month:  state_upd.month,
        cur_day:    state_upd.day,
        cur_hour:   state_upd.hour,
        cur_minute: state_upd.minute,
        cur_second: state_upd.second
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_reg <= data_next;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp_data  = data_reg;

endmodule

### hdl/calendar_clock_counter_top.sv
// Calendar clock counter: one-second ticks and validated date/time loads.
// An accepted request is held in the request register, then registered into the result register.
// Throughput: one request per cycle while rsp_stall is low; the calendar update is the limit.
// Reset (async, active low): 2011-01-01 00:00:00, both pipeline stages empty.
// Depends on ccc_pkg, ccc_in_stage, ccc_core, ccc_out_stage and the macros header.
`include "calendar_clock_counter_top_macros.svh"

module calendar_clock_counter_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ccc_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ccc_pkg::rsp_t rsp_data
);

    // Pipeline: request register -> calendar update -> result register.
    // The state registers advance when a request moves into the result
    // register, so results leave in request order, one per request.
    logic                core_fire;
    logic                out_take;
    ccc_pkg::req_t       core_item;
    ccc_pkg::cal_state_t cur_state;
    ccc_pkg::cal_state_t upd_state;

    // Terms checked by the assertions below.
    logic                time_ok;
    logic                residues_ok;
    logic                result_matches;

    // Request register; stalls only while it holds a request and the result
    // register is full and stalled.
    ccc_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .take      (out_take),
        .fire      (core_fire),
        .item      (core_item)
    );

    // Calendar state and update logic (tick carry chain or load validation).
    ccc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (core_fire),
        .item      (core_item),
        .state     (cur_state),
        .state_upd (upd_state)
    );

    // Result register; takes a new result whenever empty or being drained.
    ccc_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (core_fire),
        .state_upd (upd_state),
        .take      (out_take),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    // ---- assertions ----
    // Stored time fields stay in range; month zero is legal after a load.
    assign time_ok = (cur_state.second < ccc_pkg::SEC_LIMIT) &&
                     (cur_state.minute < ccc_pkg::MIN_LIMIT) &&
                     (cur_state.hour < ccc_pkg::HOUR_LIMIT) &&
                     (cur_state.month <= ccc_pkg::MONTH_LAST) &&
                     (cur_state.day != 5'd0);

    // Year % 400 is year % 100 plus a whole number of centuries.
    assign residues_ok = (cur_state.yr_mod400 == {2'b00, cur_state.yr_mod100}) ||
                         (cur_state.yr_mod400 == {2'b00, cur_state.yr_mod100} + 9'd100) ||
                         (cur_state.yr_mod400 == {2'b00, cur_state.yr_mod100} + 9'd200) ||
                         (cur_state.yr_mod400 == {2'b00, cur_state.yr_mod100} + 9'd300);

    // Result register contents against the calendar state.
    assign result_matches = (rsp_data.cur_year == cur_state.year) &&
                            (rsp_data.cur_month == cur_state.month) &&
                            (rsp_data.cur_day == cur_state.day) &&
                            (rsp_data.cur_hour == cur_state.hour) &&
                            (rsp_data.cur_minute == cur_state.minute) &&
                            (rsp_data.cur_second == cur_state.second);

    `CCC_ASSERT_NOW(a_time_range, 1'b1, time_ok)
    `CCC_ASSERT_NOW(a_residues, 1'b1, residues_ok)
    // The result leaving matches the state the request left behind.
    `CCC_ASSERT_NEXT(a_result_state, core_fire, rsp_valid && result_matches)
    // Requests back up only behind a stalled, full result register.
    `CCC_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall)

endmodule

### dv/calendar_clock_counter_checker.sv
`timescale 1ns / 100ps
// Scoreboard for calendar_clock_counter_top: predicts the date and time after each request.
// Compares each accepted response in order. Depends on ccc_pkg for the request/response types.
module calendar_clock_counter_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_stall,
    input  ccc_pkg::req_t req_data,
    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  ccc_pkg::rsp_t rsp_data,
    output int            fail_count,
    output int            pending,
    output int            req_count,
    output int            rsp_count,
    output int            load_count,
    output int            carry_count
);

    localparam int YEAR_MIN      = 1920;
    localparam int YEAR_MAX      = 2020;
    localparam int YEAR_FALLBACK = 2011;
    localparam int YEAR_WRAP     = 9999;
    localparam int SHOW_MAX      = 10;

    ccc_pkg::rsp_t calendar;
    ccc_pkg::rsp_t expected_q[$];
    int            n_fail;
    int            n_req;
    int            n_rsp;
    int            n_load;
    int            n_carry;

    function automatic bit leap_year(input int y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic bit day_fits(input int d, input int m, input int y);
        int last;
        case (m)
            1, 3, 5, 7, 8, 10, 12: last = 31;
            4, 6, 9, 11:           last = 30;
            2:                     last = leap_year(y) ? 29 : 28;
            default:               last = 0;   // month 0 has no valid day
        endcase
        return (d >= 1) && (d <= last);
    endfunction

    // Date and time after one request applied to 'now'
    function automatic ccc_pkg::rsp_t next_calendar(input ccc_pkg::rsp_t now,
                                                    input ccc_pkg::req_t r);
        ccc_pkg::rsp_t nxt;
        int            yr;
        bit            carry;
        nxt = now;
        if (r.req_type == ccc_pkg::REQ_LOAD)
        begin
            // year first, then month, then day checked against both
            yr = (r.set_year < YEAR_MIN || r.set_year > YEAR_MAX) ? YEAR_FALLBACK
                                                                  : int'(r.set_year);
            nxt.cur_year   = 14'(yr);
            nxt.cur_month  = (r.set_month < 13) ? r.set_month : 4'd1;
            nxt.cur_day    = day_fits(int'(r.set_day), int'(nxt.cur_month), yr)
                             ? r.set_day : 5'd1;
            nxt.cur_hour   = (r.set_hour < 24) ? r.set_hour : 5'd0;
            nxt.cur_minute = (r.set_minute < 60) ? r.set_minute : 6'd0;
            nxt.cur_second = (r.set_second < 60) ? r.set_second : 6'd0;
        end
        else
        begin
            nxt.cur_second = now.cur_second + 6'd1;
            carry = (nxt.cur_second == 6'd60);
            if (carry)
            begin
                nxt.cur_second = 6'd0;
                nxt.cur_minute = now.cur_minute + 6'd1;
                carry = (nxt.cur_minute == 6'd60);
            end
            if (carry)
            begin
                nxt.cur_minute = 6'd0;
                nxt.cur_hour = now.cur_hour + 5'd1;
                carry = (nxt.cur_hour == 5'd24);
            end
            if (carry)
            begin
                nxt.cur_hour = 5'd0;
                if (day_fits(int'(now.cur_day) + 1, int'(now.cur_month), int'(now.cur_year)))
                begin
                    nxt.cur_day = now.cur_day + 5'd1;
                end
                else
                begin
                    nxt.cur_day = 5'd1;
                    if (now.cur_month >= 12)
                    begin
                        nxt.cur_month = 4'd1;
                        nxt.cur_year  = (now.cur_year >= YEAR_WRAP) ? 14'd0
                                                                     : now.cur_year + 14'd1;
                    end
                    else
                    begin
                        nxt.cur_month = now.cur_month + 4'd1;
                    end
                end
            end
        end
        return nxt;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        ccc_pkg::rsp_t want;
        if (!rst_n)
        begin
            calendar = '{cur_year: 14'd2011, cur_month: 4'd1, cur_day: 5'd1,
                         cur_hour: 5'd0, cur_minute: 6'd0, cur_second: 6'd0};
            expected_q.delete();
            n_fail  = 0;
            n_req   = 0;
            n_rsp   = 0;
            n_load  = 0;
            n_carry = 0;
        end
        else
        begin
            // response first: it can never belong to the request taken this same edge
            if (rsp_valid && !rsp_stall)
            begin
                n_rsp++;
                if (expected_q.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= SHOW_MAX)
                        $display("unexpected response %0d: %0d-%0d-%0d %0d:%0d:%0d", n_rsp,
                                 rsp_data.cur_year, rsp_data.cur_month, rsp_data.cur_day,
                                 rsp_data.cur_hour, rsp_data.cur_minute, rsp_data.cur_second);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp_data.cur_year   !== want.cur_year   ||
                        rsp_data.cur_month  !== want.cur_month  ||
                        rsp_data.cur_day    !== want.cur_day    ||
                        rsp_data.cur_hour   !== want.cur_hour   ||
                        rsp_data.cur_minute !== want.cur_minute ||
                        rsp_data.cur_second !== want.cur_second)
                    begin
                        n_fail++;
                        if (n_fail <= SHOW_MAX)
                            $display("mismatch on response %0d: ", n_rsp,
                                     "expected %0d-%0d-%0d %0d:%0d:%0d, ",
                                     want.cur_year, want.cur_month, want.cur_day,
                                     want.cur_hour, want.cur_minute, want.cur_second,
                                     "got %0d-%0d-%0d %0d:%0d:%0d",
                                     rsp_data.cur_year, rsp_data.cur_month, rsp_data.cur_day,
                                     rsp_data.cur_hour, rsp_data.cur_minute, rsp_data.cur_second);
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                n_req++;
                want = next_calendar(calendar, req_data);
                if (req_data.req_type == ccc_pkg::REQ_LOAD)
                    n_load++;
                else if (want.cur_day != calendar.cur_day)
                    n_carry++;
                calendar = want;
                expected_q.push_back(want);
            end
        end
        fail_count  <= n_fail;
        pending     <= expected_q.size();
        req_count   <= n_req;
        rsp_count   <= n_rsp;
        load_count  <= n_load;
        carry_count <= n_carry;
    end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Top of the calendar_clock_counter_top testbench: clock, reset, request stimulus, verdict.
// Depends on ccc_pkg, the block itself and calendar_clock_counter_checker.
module tb;

    localparam int RANDOM_ITEMS   = 1700;
    localparam int HOLD_CYCLES    = 160;   // long response hold-off, fills the block
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either side
    localparam int DRAIN_CYCLES   = 8;     // margin for stray responses after the last expected one

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    ccc_pkg::req_t req_data;
    logic          rsp_valid;
    logic          rsp_stall;
    ccc_pkg::rsp_t rsp_data;

    int fail_count;
    int pending;
    int req_count;
    int rsp_count;
    int load_count;
    int carry_count;

    calendar_clock_counter_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    calendar_clock_counter_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_data    (rsp_data),
        .fail_count  (fail_count),
        .pending     (pending),
        .req_count   (req_count),
        .rsp_count   (rsp_count),
        .load_count  (load_count),
        .carry_count (carry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Both sides run without any idling while their transfer count sits in this
    // window, so back-to-back traffic is seen for a few hundred requests.
    function automatic bit steady_window(input int n);
        return (n >= 900) && (n < 1250);
    endfunction

    function automatic bit idle_roll(input int n);
        return !steady_window(n) && ($urandom_range(99) < 31);
    endfunction

    function automatic ccc_pkg::req_t load_req(input int y, input int m, input int d,
                                               input int h, input int mi, input int s);
        ccc_pkg::req_t r;
        r.req_type   = ccc_pkg::REQ_LOAD;
        r.set_year   = 12'(y);
        r.set_month  = 4'(m);
        r.set_day    = 5'(d);
        r.set_hour   = 5'(h);
        r.set_minute = 6'(mi);
        r.set_second = 6'(s);
        return r;
    endfunction

    // Tick with junk in the load fields: the block must ignore them
    function automatic ccc_pkg::req_t tick_req();
        ccc_pkg::req_t r;
        r = load_req($urandom_range(4095), $urandom_range(15), $urandom_range(31),
                     $urandom_range(31), $urandom_range(63), $urandom_range(63));
        r.req_type = ccc_pkg::REQ_TICK;
        return r;
    endfunction

    // Legal-looking load parked just before a rollover, so that the ticks that
    // follow carry into minutes, hours, days, months and now and then the year.
    function automatic ccc_pkg::req_t near_rollover_load();
        int y;
        int m;
        int d;
        y = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(1920, 2020);
        m = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 12);
        d = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(27, 31);
        if ($urandom_range(7) == 0)
        begin
            m = 12;
            d = 31;
        end
        return load_req(y, m, d,
                        $urandom_range(1) ? 23 : $urandom_range(23),
                        ($urandom_range(3) != 0) ? 59 : $urandom_range(59),
                        $urandom_range(54, 59));
    endfunction

    // Offer one request. Entered and left at a falling edge; valid stays high
    // from one request to the next unless an idle cycle is rolled.
    task automatic send_req(input ccc_pkg::req_t r);
        while (idle_roll(req_count))
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Response side: random stalls, plus one long hold-off while the sender
    // keeps pushing, which backs the block up until it stalls its input.
    initial
    begin : receiver
        int  hold;
        bit  hold_done;
        rsp_stall = 1'b0;
        hold      = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && rsp_count >= 500)
            begin
                hold      = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold > 0)
            begin
                hold--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= idle_roll(rsp_count);
            end
        end
    end

    // Ends the run if neither channel moves for too long
    initial
    begin : watchdog
        int still;
        still = 0;
        while (still < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                still = 0;
            else
                still++;
        end
        $display("watchdog: no transfer for %0d cycles, %0d responses outstanding",
                 WATCHDOG_LIMIT, pending);
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int sent;
        int pick;
        int n;
        req_valid = 1'b0;
        req_data  = '0;
        rst_n     = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ---- directed part ----
        send_req(tick_req());                           // from reset value 2011-01-01
        send_req(load_req(4095, 15, 31, 31, 63, 63));   // every field at its top code
        send_req(load_req(0, 0, 0, 0, 0, 0));           // all zero: month zero kept
        send_req(load_req(2015, 0, 15, 23, 59, 59));    // month zero, day forced to 1
        send_req(tick_req());                           // month zero rolls on to month 1
        send_req(load_req(2020, 12, 31, 23, 59, 59));   // upper year bound, year carry
        send_req(tick_req());
        send_req(load_req(2000, 2, 29, 23, 59, 59));    // leap by the 400 rule
        send_req(tick_req());
        send_req(load_req(1920, 2, 28, 23, 59, 59));    // lower year bound, leap by 4
        send_req(tick_req());
        send_req(tick_req());
        send_req(load_req(2019, 2, 29, 10, 20, 30));    // Feb 29 outside a leap year
        send_req(load_req(2019, 2, 28, 23, 59, 59));
        send_req(tick_req());
        send_req(load_req(1900, 2, 29, 1, 2, 3));       // century year, out of range too
        send_req(load_req(1919, 6, 30, 12, 30, 30));    // just below the year window
        send_req(load_req(2021, 4, 31, 24, 60, 60));    // just above; first invalid codes
        send_req(load_req(2010, 13, 5, 0, 0, 0));       // first month code out of range
        send_req(load_req(2015, 11, 30, 23, 59, 58));
        send_req(tick_req());
        send_req(tick_req());                           // Nov 30 -> Dec 1
        send_req(load_req(2015, 1, 31, 23, 58, 59));
        send_req(tick_req());                           // minute carry, no hour carry

        // ---- random part: mostly near-rollover loads followed by ticks ----
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                n = $urandom_range(1, 8);
                send_req(near_rollover_load());
                repeat (n) send_req(tick_req());
                sent += n + 1;
            end
            else if (pick < 85)
            begin
                send_req(load_req($urandom_range(4095), $urandom_range(15), $urandom_range(31),
                                  $urandom_range(31), $urandom_range(63), $urandom_range(63)));
                sent++;
            end
            else
            begin
                n = $urandom_range(1, 80);
                repeat (n) send_req(tick_req());
                sent += n;
            end
        end
        req_valid <= 1'b0;

        // Drain: every prediction answered, then a few more cycles for stray responses
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests (%0d loads, %0d ticks), %0d of the ticks crossed a day",
                 req_count, load_count, req_count - load_count, carry_count);
        $display("checked %0d responses, %0d failures, %0d left unanswered",
                 rsp_count, fail_count, pending);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
